// ===== src/mmexp_pkg.sv =====
// Package for the Montgomery modular exponentiation core.
// Holds default widths, reset values and register indexes; no dependencies.
package mmexp_pkg;

    localparam int MOD_WIDTH_DEF = 16;
    localparam int EXP_WIDTH_DEF = 32;
    localparam int BASE_WIDTH    = 16;
    localparam int POWER_WIDTH   = 16;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int MOD_RESET     = 3;
    localparam int NEWTON_STEPS  = 4;

    localparam logic REG_MODULUS = 1'b0;

endpackage

// ===== src/mmexp_cfg.sv =====
// APB register block holding the modulus.
// Depends on mmexp_pkg.
module mmexp_cfg import mmexp_pkg::*; #(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    output logic [MOD_WIDTH-1:0]   o_modulus
);

    logic [MOD_WIDTH-1:0] r_modulus;
    logic                 w_hit;

    assign w_hit  = (paddr[APB_ADDR_W-1] == REG_MODULUS);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_WIDTH'(MOD_RESET);
        end else if (psel && penable && pwrite && w_hit) begin
            r_modulus <= pwdata[MOD_WIDTH-1:0];
        end
    end

    assign prdata    = w_hit ? APB_DATA_W'(r_modulus) : '0;
    assign o_modulus = r_modulus;

endmodule

// ===== src/montgomery_modular_exponent_core.sv =====
// Top level: modular exponentiation by right-to-left Montgomery square-and-multiply.
// Depends on mmexp_pkg and mmexp_cfg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  request  | i_valid / o_ready  | i_base, i_exponent
//  result   | o_valid / i_ready  | o_power, o_bad_modulus
//  config   | APB psel/penable   | paddr, pwdata, prdata
//
// Each request runs a bit-serial remainder step over W + r bits (r = modulus bit
// length) and NEWTON_STEPS Newton steps for the inverse, then a Montgomery multiply
// and reduce per exponent bit up to the top set bit and one more per set bit, all on
// the single shared WxW multiplier, and a final reduce out of Montgomery form.
// A bad modulus goes straight from idle to done. Reset is synchronous and clears control.
// o_ready is high only when idle; a result waits in the output register.
module montgomery_modular_exponent_core import mmexp_pkg::*; #(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [BASE_WIDTH-1:0]  i_base,
    input  logic [EXP_WIDTH-1:0]   i_exponent,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [POWER_WIDTH-1:0] o_power,
    output logic                   o_bad_modulus,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int W     = MOD_WIDTH;
    localparam int RW    = $clog2(W + 1);
    localparam int CNT_W = $clog2(2 * W + 1);
    localparam int IT_W  = $clog2(NEWTON_STEPS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIV   = 10'b0000000010,
        S_INV_A = 10'b0000000100,
        S_INV_B = 10'b0000001000,
        S_SCAN  = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_RED_M = 10'b0001000000,
        S_RED_N = 10'b0010000000,
        S_FIX   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        D_S   = 2'b00,
        D_B   = 2'b01,
        D_FIN = 2'b10
    } t_dst;

    t_state r_state;
    t_dst   r_dst;

    logic [W-1:0]           n;
    logic [W-1:0]           r_x_shift, r_rem, r_s, r_b, r_inv, r_prod, r_ninv, r_m;
    logic [EXP_WIDTH-1:0]   r_exp;
    logic [RW-1:0]          r_r, r_calc;
    logic [CNT_W-1:0]       r_cnt;
    logic [IT_W-1:0]        r_iter;
    logic                   r_sq;
    logic [2*W:0]           r_sum;
    logic [W-1:0]           r_res;
    logic                   r_bad;
    logic                   r_out_valid;
    logic [POWER_WIDTH-1:0] r_power;
    logic                   r_out_bad;

    logic [W-1:0]   rmask, mul_a, mul_b, res, q_val;
    logic [2*W-1:0] mul_p;
    logic [W:0]     rem2, rem_n, v, fix, r_pow2;
    logic           bad_n, out_load;

    mmexp_cfg #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_modulus (n)
    );

    always_comb begin
        r_calc = '0;
        for (int i = 0; i < W; i++) begin
            if (n[i]) r_calc = RW'(i + 1);
        end
    end

    assign bad_n  = !n[0] || (n == W'(1));
    assign rmask  = {W{1'b1}} >> (RW'(W) - r_r);
    assign r_pow2 = (W+1)'(1) << r_r;

    assign rem2  = {r_rem, r_x_shift[W-1]};
    assign rem_n = (rem2 >= {1'b0, n}) ? rem2 - {1'b0, n} : rem2;

    assign q_val = W'(2) - r_prod;

    always_comb begin
        unique case (r_state)
            S_INV_A: begin mul_a = n;               mul_b = r_inv;  end
            S_INV_B: begin mul_a = r_inv;           mul_b = q_val;  end
            S_MUL:   begin mul_a = (r_dst == D_S) ? r_s : r_b; mul_b = r_b; end
            S_RED_M: begin mul_a = r_sum[W-1:0];    mul_b = r_ninv; end
            S_RED_N: begin mul_a = r_m;             mul_b = n;      end
            default: begin mul_a = '0;              mul_b = '0;     end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign v   = (W+1)'(r_sum >> r_r);
    assign fix = (v >= {1'b0, n}) ? v - {1'b0, n} : v;
    assign res = W'(fix);

    assign out_load = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x_shift <= W'(i_base);
                        r_exp     <= i_exponent;
                        r_r       <= r_calc;
                        r_cnt     <= CNT_W'(W) + CNT_W'(r_calc);
                        r_rem     <= '0;
                        if (bad_n) begin
                            r_res   <= '0;
                            r_bad   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem     <= W'(rem_n);
                    r_x_shift <= r_x_shift << 1;
                    r_cnt     <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_b     <= W'(rem_n);
                        r_s     <= W'(r_pow2 - {1'b0, n});
                        r_inv   <= n;
                        r_iter  <= '0;
                        r_state <= S_INV_A;
                    end
                end
                S_INV_A: begin
                    r_prod  <= mul_p[W-1:0];
                    r_state <= S_INV_B;
                end
                S_INV_B: begin
                    r_inv <= mul_p[W-1:0];
                    if (r_iter == IT_W'(NEWTON_STEPS - 1)) begin
                        r_ninv  <= (W'(0) - mul_p[W-1:0]) & rmask;
                        r_sq    <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_iter  <= r_iter + IT_W'(1);
                        r_state <= S_INV_A;
                    end
                end
                S_SCAN: begin
                    if (r_exp == '0) begin
                        r_sum   <= (2*W+1)'(r_s);
                        r_dst   <= D_FIN;
                        r_state <= S_RED_M;
                    end else if (!r_sq && r_exp[0]) begin
                        r_dst   <= D_S;
                        r_state <= S_MUL;
                    end else begin
                        r_dst   <= D_B;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_sum   <= (2*W+1)'(mul_p);
                    r_state <= S_RED_M;
                end
                S_RED_M: begin
                    r_m     <= mul_p[W-1:0] & rmask;
                    r_state <= S_RED_N;
                end
                S_RED_N: begin
                    r_sum   <= r_sum + (2*W+1)'(mul_p);
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    unique case (r_dst)
                        D_S: begin
                            r_s     <= res;
                            r_sq    <= 1'b1;
                            r_state <= S_SCAN;
                        end
                        D_B: begin
                            r_b     <= res;
                            r_sq    <= 1'b0;
                            r_exp   <= r_exp >> 1;
                            r_state <= S_SCAN;
                        end
                        D_FIN: begin
                            r_res   <= res;
                            r_bad   <= 1'b0;
                            r_state <= S_DONE;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_DONE: begin
                    if (out_load) begin
                        r_power     <= POWER_WIDTH'(r_res);
                        r_out_bad   <= r_bad;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_power       = r_power;
    assign o_bad_modulus = r_out_bad;

endmodule
